>>> rtl/core/fts_pkg.sv
// Package for the frame timer: shared types, register codes and constants.
// No dependencies; imported by every module of the frame timer but fts_chk.
package fts_pkg;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 20;
  localparam int FT_W = 28;
  localparam int ACC_W = 29;
  localparam int CNT_W = 32;
  localparam int DIV_N = 64;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_DELTA = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIXED_STEP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_SCALE = 2'd2;

  localparam logic [19:0] MAX_DELTA_RST = 20'd60000;
  localparam logic [19:0] FIXED_STEP_RST = 20'd60000;
  localparam logic [15:0] TIME_SCALE_RST = 16'd256;

  // one second in microseconds, times 256 for Q8 rates
  localparam logic [27:0] US_PER_S_Q8 = 28'd256000000;

  typedef enum logic [1:0] {
    DIV_TICK,
    DIV_WIN,
    DIV_AVG
  } div_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FRONT,
    ST_SCALE,
    ST_ACCUM,
    ST_TICK_GO,
    ST_TICK_RUN,
    ST_WIN_GO,
    ST_WIN_RUN,
    ST_AVG_GO,
    ST_AVG_RUN,
    ST_PUBLISH
  } state_t;

  typedef struct packed {
    logic     load_in;
    logic     front;
    logic     scale;
    logic     accum;
    logic     div_start;
    div_sel_t div_sel;
    logic     cap_div;
    logic     publish;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

>>> rtl/core/frame_timer_fixed_step.sv
// Top level of the frame timer with fixed-step accumulator and rate averages.
// Depends on fts_pkg, fts_ctrl, fts_dp (which holds fts_div).
//
//  channel  | direction | handshake                    | payload
//  ---------+-----------+------------------------------+-----------------------------
//  cfg      | in        | cfg_valid / cfg_ready        | cfg_index, cfg_data
//  s_axis   | in        | s_axis_tvalid / s_axis_tready| now_us
//  m_axis   | out       | m_axis_tvalid / m_axis_tready| frame time, ticks, counts, rates
//
// From accept to result a frame passes the setup steps, then the single shared
// 64-step divider runs three times (ticks, window rate, average rate). The
// divider sets the rate; a new frame is taken only once the previous result
// is in the output register.
// Reset clears all timing state and the ring valid bits at once; no clear sweep.
// A stalled result holds in the output register; the next frame is accepted
// and processed meanwhile and waits in the publish step until the register frees.
module frame_timer_fixed_step #(
  parameter int WINDOW = 240,
  parameter int TIME_BITS = 48,
  parameter int SCALE_FRAC_BITS = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  // config write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fts_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fts_pkg::CFG_DATA_W-1:0]  cfg_data,
  // frame timestamps
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [((TIME_BITS+7)/8)*8-1:0]  s_axis_tdata,  // now_us, zero pad
  // results
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // frame_time_us, ticks_now, total_ticks, frames_seen, elapsed_us,
  // window_rate_q8, average_rate_q8, zero pad
  output logic [((184+TIME_BITS+7)/8)*8-1:0] m_axis_tdata
);
  import fts_pkg::*;

  localparam int IN_W = ((TIME_BITS + 7) / 8) * 8;
  localparam int OUT_W = ((184 + TIME_BITS + 7) / 8) * 8;

  cmd_t cmd;
  sts_t sts;

  // config registers take a write in any cycle
  assign cfg_ready = 1'b1;

  fts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fts_dp #(
    .WINDOW          (WINDOW),
    .TIME_BITS       (TIME_BITS),
    .SCALE_FRAC_BITS (SCALE_FRAC_BITS),
    .IN_W            (IN_W),
    .OUT_W           (OUT_W)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_axis_tdata),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

>>> rtl/core/fts_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on fts_pkg.
module fts_div #(
  parameter int DVW = 48
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [fts_pkg::DIV_N-1:0] dividend,
  input  logic [DVW-1:0]         divisor,
  output logic                   done,
  output logic [fts_pkg::DIV_N-1:0] quotient,
  output logic [DVW-1:0]         remainder
);
  import fts_pkg::*;

  localparam int CW = $clog2(DIV_N);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DVW-1:0] dsr;
  logic [DVW:0]  shifted;
  logic          fits;

  assign shifted = {remainder, quotient[DIV_N-1]};
  assign fits = shifted >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(DIV_N - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      dsr       <= divisor;
    end else if (busy) begin
      quotient  <= {quotient[DIV_N-2:0], fits};
      remainder <= fits ? DVW'(shifted - {1'b0, dsr}) : shifted[DVW-1:0];
    end
  end

endmodule

>>> rtl/core/fts_ctrl.sv
// Sequencer for the frame timer: walks one frame through the datapath.
// Depends on fts_pkg.
module fts_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  fts_pkg::sts_t sts,
  output fts_pkg::cmd_t cmd
);
  import fts_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.div_sel = DIV_TICK;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next = ST_FRONT;
        end
      end
      ST_FRONT: begin
        cmd.front = 1'b1;
        state_next = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.scale = 1'b1;
        state_next = ST_ACCUM;
      end
      ST_ACCUM: begin
        cmd.accum = 1'b1;
        state_next = ST_TICK_GO;
      end
      ST_TICK_GO: begin
        cmd.div_start = 1'b1;
        state_next = ST_TICK_RUN;
      end
      ST_TICK_RUN: begin
        if (sts.div_done) begin
          cmd.cap_div = 1'b1;
          state_next = ST_WIN_GO;
        end
      end
      ST_WIN_GO: begin
        cmd.div_sel = DIV_WIN;
        cmd.div_start = 1'b1;
        state_next = ST_WIN_RUN;
      end
      ST_WIN_RUN: begin
        cmd.div_sel = DIV_WIN;
        if (sts.div_done) begin
          cmd.cap_div = 1'b1;
          state_next = ST_AVG_GO;
        end
      end
      ST_AVG_GO: begin
        cmd.div_sel = DIV_AVG;
        cmd.div_start = 1'b1;
        state_next = ST_AVG_RUN;
      end
      ST_AVG_RUN: begin
        cmd.div_sel = DIV_AVG;
        if (sts.div_done) begin
          cmd.cap_div = 1'b1;
          state_next = ST_PUBLISH;
        end
      end
      ST_PUBLISH: begin
        if (sts.out_free) begin
          cmd.publish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/fts_dp.sv
// Datapath for the frame timer: config registers, timing state, history ring,
// scale and rate multipliers, shared divider and output register. Uses fts_pkg, fts_div.
module fts_dp #(
  parameter int WINDOW = 240,
  parameter int TIME_BITS = 48,
  parameter int SCALE_FRAC_BITS = 8,
  parameter int IN_W = 48,
  parameter int OUT_W = 232
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic [fts_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fts_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [IN_W-1:0]                 in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [OUT_W-1:0]                out_data,
  input  fts_pkg::cmd_t                   cmd,
  output fts_pkg::sts_t                   sts
);
  import fts_pkg::*;

  localparam int PW = $clog2(WINDOW);
  localparam int WS_W = FT_W + $clog2(WINDOW + 1);
  localparam int DVA = (TIME_BITS > WS_W) ? TIME_BITS : WS_W;
  localparam int DVW = (DVA > 20) ? DVA : 20;
  localparam logic [DIV_N-1:0] WIN_NUM = DIV_N'(WINDOW) * DIV_N'(US_PER_S_Q8);
  localparam int FIELD_W = 4 * FT_W + 4 * CNT_W - 2 * FT_W + TIME_BITS;

  logic [19:0] max_delta;
  logic [19:0] fixed_step;
  logic [15:0] time_scale;

  logic                 started;
  logic [TIME_BITS-1:0] now_reg, prev_time, elapsed, base, delta;
  logic [CNT_W-1:0]     frames, ticks_total;
  logic [ACC_W-1:0]     acc;
  logic [19:0]          clamped;
  logic [35:0]          prod, prod_shift;
  logic [FT_W-1:0]      ft, ft_reg;
  logic [DIV_N-1:0]     avg_num;
  logic [WS_W-1:0]      wsum;
  logic [PW-1:0]        pos;

  logic [FT_W-1:0]      ring [WINDOW];
  logic [WINDOW-1:0]    ring_vld;
  logic [FT_W-1:0]      old_raw;
  logic                 old_vld;
  logic [FT_W-1:0]      old_ft;

  logic [FT_W-1:0]      ticks_now;
  logic [CNT_W-1:0]     win_rate, avg_rate;

  logic [DIV_N-1:0]     div_num, div_q;
  logic [DVW-1:0]       div_den, div_rem;
  logic                 div_done;
  logic [CNT_W-1:0]     rate_sat;
  logic                 den_zero;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      max_delta  <= MAX_DELTA_RST;
      fixed_step <= FIXED_STEP_RST;
      time_scale <= TIME_SCALE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MAX_DELTA:  max_delta  <= cfg_data;
        REG_FIXED_STEP: fixed_step <= cfg_data;
        REG_TIME_SCALE: time_scale <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign base  = started ? prev_time : now_reg;
  assign delta = now_reg - base;
  assign prod_shift = prod >> SCALE_FRAC_BITS;
  assign ft = (|prod_shift[35:FT_W]) ? {FT_W{1'b1}} : prod_shift[FT_W-1:0];
  assign old_ft = old_vld ? old_raw : '0;

  // control state of the timer
  always_ff @(posedge clk) begin
    if (rst) begin
      started     <= 1'b0;
      prev_time   <= '0;
      elapsed     <= '0;
      frames      <= '0;
      ticks_total <= '0;
      acc         <= '0;
      wsum        <= '0;
      pos         <= '0;
      ring_vld    <= '0;
    end else begin
      if (cmd.front) begin
        started   <= 1'b1;
        prev_time <= now_reg;
        elapsed   <= elapsed + delta;
        frames    <= frames + 1'b1;
        // first frame preloads one step, so it yields one tick
        if (!started) begin
          acc <= ACC_W'(fixed_step);
        end
      end
      if (cmd.accum) begin
        acc  <= acc + ACC_W'(ft);
        wsum <= wsum - WS_W'(old_ft) + WS_W'(ft);
        ring_vld[pos] <= 1'b1;
        pos <= (pos == PW'(WINDOW - 1)) ? '0 : pos + 1'b1;
      end
      if (cmd.cap_div && cmd.div_sel == DIV_TICK) begin
        if (fixed_step == '0) begin
          acc <= '0;
        end else begin
          acc <= div_rem[ACC_W-1:0];
          ticks_total <= ticks_total + div_q[CNT_W-1:0];
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      now_reg <= in_data[TIME_BITS-1:0];
    end
    if (cmd.front) begin
      clamped <= (delta < TIME_BITS'(max_delta)) ? delta[19:0] : max_delta;
    end
    if (cmd.scale) begin
      prod <= 36'(clamped) * 36'(time_scale);
    end
    if (cmd.accum) begin
      ft_reg  <= ft;
      avg_num <= DIV_N'(frames) * DIV_N'(US_PER_S_Q8);
    end
  end

  // history ring
  always_ff @(posedge clk) begin
    if (cmd.front) begin
      old_raw <= ring[pos];
      old_vld <= ring_vld[pos];
    end
    if (cmd.accum) begin
      ring[pos] <= ft;
    end
  end

  always_comb begin
    case (cmd.div_sel)
      DIV_TICK: begin
        div_num = DIV_N'(acc);
        div_den = DVW'(fixed_step);
      end
      DIV_WIN: begin
        div_num = WIN_NUM;
        div_den = DVW'(wsum);
      end
      DIV_AVG: begin
        div_num = avg_num;
        div_den = DVW'(elapsed);
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  fts_div #(.DVW(DVW)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (div_num),
    .divisor   (div_den),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  assign den_zero = (div_den == '0);
  assign rate_sat = den_zero ? '0 :
                    (|div_q[DIV_N-1:CNT_W]) ? {CNT_W{1'b1}} : div_q[CNT_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.cap_div) begin
      case (cmd.div_sel)
        DIV_TICK: begin
          if (den_zero) begin
            ticks_now <= '0;
          end else begin
            ticks_now <= (|div_q[DIV_N-1:FT_W]) ? {FT_W{1'b1}} : div_q[FT_W-1:0];
          end
        end
        DIV_WIN: win_rate <= rate_sat;
        DIV_AVG: avg_rate <= rate_sat;
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_data <= OUT_W'({avg_rate, win_rate, elapsed, frames, ticks_total,
                          ticks_now, ft_reg});
    end
  end

  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid || out_ready;

  // FIELD_W documents the packed result width ahead of byte padding
  if (FIELD_W > OUT_W) begin : g_width_guard
    $error("output field width exceeds tdata");
  end

endmodule

>>> rtl/core/fts_chk.sv
// Port-level checks for the frame timer, bound onto the top level.
// Depends on frame_timer_fixed_step ports only.
module fts_chk #(
  parameter int OUT_W = 232
) (
  input logic             clk,
  input logic             rst,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata
);

  // busy after taking a frame
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after a transaction");

  // a new frame does not disturb the held result
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed right after input transaction");

  // no result straight out of reset
  assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // a stalled result stays offered
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

endmodule

bind frame_timer_fixed_step fts_chk #(.OUT_W(OUT_W)) u_fts_chk (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
